// ----- hw/rtl/stw_pkg.sv -----
// Shared types, codes and constants of the stream timeout watchdog.
package stw_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_BITS      = 32;
    localparam int TMO_BITS      = 32;
    localparam int QUIET_BITS    = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [1:0] CMD_RESTART  = 2'd0;
    localparam logic [1:0] CMD_CHUNK    = 2'd1;
    localparam logic [1:0] CMD_EVALUATE = 2'd2;

    localparam logic [1:0] STATE_WAITING = 2'd0;
    localparam logic [1:0] STATE_RUNNING = 2'd1;
    localparam logic [1:0] STATE_HOLD    = 2'd2;
    localparam logic [1:0] STATE_ABORTED = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_STREAM_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIMEOUT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RESUME_ON_CHUNK = 2'd2;

    typedef enum logic [3:0] {
        MODE_WAITING = 4'b0001,
        MODE_RUNNING = 4'b0010,
        MODE_HOLD    = 4'b0100,
        MODE_ABORTED = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [1:0]          command;
        logic [NOW_BITS-1:0] now;
    } t_item;

    typedef struct packed {
        logic [1:0]            stream_state;
        logic [QUIET_BITS-1:0] quiet_ticks;
    } t_result;

    typedef struct packed {
        logic                     we;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_wr;

    function automatic logic [1:0] mode_code(t_mode m);
        logic [1:0] code;
        unique case (m)
            MODE_WAITING: code = STATE_WAITING;
            MODE_RUNNING: code = STATE_RUNNING;
            MODE_HOLD:    code = STATE_HOLD;
            MODE_ABORTED: code = STATE_ABORTED;
            default:      code = STATE_WAITING;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/stw_ifs.sv -----
// Valid/ready stream interfaces for the watchdog input and result channels.
interface stw_in_if
    import stw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic [NOW_BITS-1:0] now;

    modport source (output valid, output command, output now, input ready);
    modport sink   (input valid, input command, input now, output ready);
endinterface

interface stw_out_if
    import stw_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [1:0]            stream_state;
    logic [QUIET_BITS-1:0] quiet_ticks;

    modport source (output valid, output stream_state, output quiet_ticks, input ready);
    modport sink   (input valid, input stream_state, input quiet_ticks, output ready);
endinterface

// ----- hw/rtl/stw_in_stage.sv -----
// Input register stage: captures one command transaction per cycle while o_ready is high.
module stw_in_stage
    import stw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_take,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- hw/rtl/stw_core.sv -----
// Watchdog state, configuration registers and next-state/result logic.
module stw_core
    import stw_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int CW = (TIME_BITS > TMO_BITS) ? TIME_BITS : TMO_BITS;

    logic [TMO_BITS-1:0]  r_stream_tmo;
    logic [TMO_BITS-1:0]  r_hold_tmo;
    logic                 r_resume;

    t_mode                r_mode,       n_mode;
    logic [TIME_BITS-1:0] r_start,      n_start;
    logic [TIME_BITS-1:0] r_last,       n_last;
    logic                 r_seen,       n_seen;
    logic [TIME_BITS-1:0] r_hold_start, n_hold_start;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] ref_t;
    logic [TIME_BITS-1:0] quiet_t;
    logic                 stream_expired;
    logic                 hold_expired;

    function automatic logic [TIME_BITS-1:0] elapsed(logic [TIME_BITS-1:0] now,
                                                    logic [TIME_BITS-1:0] base);
        return (now >= base) ? (now - base) : '0;
    endfunction

    assign now_t = TIME_BITS'(i_item.now);
    assign ref_t = r_seen ? r_last : r_start;
    assign stream_expired = CW'(elapsed(now_t, ref_t)) > CW'(r_stream_tmo);
    assign hold_expired   = (r_hold_tmo != '0) &&
                            (CW'(elapsed(now_t, r_hold_start)) > CW'(r_hold_tmo));

    always_comb begin
        n_mode       = r_mode;
        n_start      = r_start;
        n_last       = r_last;
        n_seen       = r_seen;
        n_hold_start = r_hold_start;
        unique case (i_item.command)
            CMD_RESTART: begin
                n_mode       = MODE_WAITING;
                n_start      = now_t;
                n_last       = now_t;
                n_seen       = 1'b0;
                n_hold_start = now_t;
            end
            CMD_CHUNK: begin
                n_last = now_t;
                n_seen = 1'b1;
                if (r_mode == MODE_WAITING || (r_mode == MODE_HOLD && r_resume)) begin
                    n_mode = MODE_RUNNING;
                end
            end
            CMD_EVALUATE: begin
                if (r_stream_tmo != '0) begin
                    if ((r_mode == MODE_WAITING || r_mode == MODE_RUNNING) &&
                        stream_expired) begin
                        n_mode       = MODE_HOLD;
                        n_hold_start = now_t;
                    end else if (r_mode == MODE_HOLD && hold_expired) begin
                        n_mode = MODE_ABORTED;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign quiet_t = n_seen ? elapsed(now_t, n_last) : '0;

    always_comb begin
        o_result.stream_state = mode_code(n_mode);
        if (CW'(quiet_t) > CW'({QUIET_BITS{1'b1}})) begin
            o_result.quiet_ticks = {QUIET_BITS{1'b1}};
        end else begin
            o_result.quiet_ticks = QUIET_BITS'(quiet_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_tmo <= '0;
            r_hold_tmo   <= '0;
            r_resume     <= 1'b0;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                REG_STREAM_TIMEOUT:  r_stream_tmo <= TMO_BITS'(i_cfg.data);
                REG_HOLD_TIMEOUT:    r_hold_tmo   <= TMO_BITS'(i_cfg.data);
                REG_RESUME_ON_CHUNK: r_resume     <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_WAITING;
            r_start      <= '0;
            r_last       <= '0;
            r_seen       <= 1'b0;
            r_hold_start <= '0;
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_start      <= n_start;
            r_last       <= n_last;
            r_seen       <= n_seen;
            r_hold_start <= n_hold_start;
        end
    end

endmodule

// ----- hw/rtl/stw_out_stage.sv -----
// Output register stage: holds one result transaction until the sink takes it.
module stw_out_stage
    import stw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- hw/rtl/stream_timeout_watchdog_top.sv -----
// Stream timeout watchdog: command transactions in, one mode/quiet-time result out each.
//
// Channels: s_in carries a command (restart, chunk, evaluate) and a tick
// timestamp; m_out returns the mode after the command and the ticks since
// the last chunk. Both are valid/ready; a transaction moves when both are high.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 stream timeout, 1 hold timeout, 2 resume on chunk) at the clock edge.
// Path: an accepted command is held in the input register, the core forms its
// result from it, and the result register holds that result for m_out.
// Throughput: one transaction per cycle while m_out does not hold off; state
// update and result are formed by compare/subtract logic between the two registers.
// Stall: while m_out is held off, the result register keeps its data, the
// input register keeps one more command, and s_in.ready drops only when both
// are full.
// Reset (synchronous, i_rst_n low): no results pending, mode waiting for the
// first chunk, all times, flags and configuration registers cleared.
module stream_timeout_watchdog_top
    import stw_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    stw_in_if.sink                   s_in,
    stw_out_if.source                m_out
);

    t_item   in_item;
    t_item   st_item;
    t_result core_res;
    t_result out_res;
    t_cfg_wr cfg;
    logic    st_valid;
    logic    out_ready;
    logic    fire;
    logic    in_ready;
    logic    out_valid;

    assign in_item.command = s_in.command;
    assign in_item.now     = s_in.now;
    assign s_in.ready      = in_ready;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    assign fire = st_valid && out_ready;

    stw_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_in.valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (st_valid),
        .i_take  (out_ready),
        .o_item  (st_item)
    );

    stw_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_item   (st_item),
        .o_result (core_res)
    );

    stw_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (st_valid),
        .o_ready  (out_ready),
        .i_result (core_res),
        .o_valid  (out_valid),
        .i_ready  (m_out.ready),
        .o_result (out_res)
    );

    assign m_out.valid        = out_valid;
    assign m_out.stream_state = out_res.stream_state;
    assign m_out.quiet_ticks  = out_res.quiet_ticks;

endmodule
